>>> design/rle_image_run_decoder_unit_defines.svh
// Assertion macros used by the run-length decoder top level.
`ifndef RLE_IMAGE_RUN_DECODER_UNIT_DEFINES_SVH
`define RLE_IMAGE_RUN_DECODER_UNIT_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define RID_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define RID_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> design/rid_pkg.sv
// Shared types and constants of the run-length image decoder.
package rid_pkg;

   localparam int DEF_MAX_COLUMNS = 4096;
   localparam int DEF_MAX_ROWS    = 4096;

   localparam int CODE_W   = 16;
   localparam int COLOR_W  = 16;
   localparam int LEN_W    = 15;
   localparam int POS_W    = 12;
   localparam int DIM_W    = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Divider retires this many quotient bits per cycle.
   localparam int DIVIDEND_W    = 16;
   localparam int DIV_BITS_STEP = 4;
   localparam int DIV_STEPS     = DIVIDEND_W / DIV_BITS_STEP;
   localparam int STEP_W        = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJ_COLOR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BCK_COLOR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_COUNT = 3'd4;

   localparam logic               MODE_ALPHA      = 1'b0;
   localparam logic               MODE_RESET      = 1'b1;
   localparam logic [COLOR_W-1:0] OBJ_COLOR_RESET = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BCK_COLOR_RESET = 16'h0000;
   localparam logic [DIM_W-1:0]   WIDTH_RESET     = 13'd170;
   localparam logic [DIM_W-1:0]   COUNT_RESET     = 13'd320;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_REPEAT,
      PH_LITERAL
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic mix;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic header_word;
   } dp_status_type;

endpackage

>>> design/rid_ctrl.sv
// Controller state machine of the run-length image decoder.
module rid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rid_pkg::dp_status_type status,
   output rid_pkg::ctrl_cmd_type  cmd
);
   import rid_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.mix      = (step_ff == '0);
         end
         ST_EMIT: begin
            cmd.emit = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.header_word) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/rid_datapath.sv
// Datapath of the run-length image decoder: registers, header decode, divider, colour mix.
module rid_datapath #(
   parameter int MAX_COLUMNS = rid_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = rid_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [rid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rid_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic [rid_pkg::CODE_W-1:0]       req_code_word,
   input  logic                             req_start_of_image,
   input  rid_pkg::ctrl_cmd_type            cmd,
   output rid_pkg::dp_status_type           status,
   output logic [rid_pkg::COLOR_W-1:0]      rsp_color,
   output logic [rid_pkg::LEN_W-1:0]        rsp_run_length,
   output logic [rid_pkg::POS_W-1:0]        rsp_start_column,
   output logic [rid_pkg::POS_W-1:0]        rsp_start_row,
   output logic                             rsp_image_end
);
   import rid_pkg::*;

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int ROW_W = $clog2(MAX_ROWS);

   // Configuration registers.
   logic               mode_ff;
   logic [COLOR_W-1:0] obj_ff, bck_ff;
   logic [DIM_W-1:0]   lwidth_ff, lcount_ff;
   logic [DIM_W-1:0]   wdim, hdim;

   // Decoder state.
   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   phase_type        eff_phase;
   logic [LEN_W-1:0] eff_count, run_len, lit_left;
   logic [COL_W-1:0] eff_col;
   logic [ROW_W-1:0] eff_row;
   logic [CODE_W-1:0] hdr_sext, hdr_neg;
   logic [LEN_W-1:0]  hdr_neg_sat;

   // Value word and divider.
   logic [CODE_W-1:0]     word_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIM_W-1:0]      rem_ff, rem_in;
   logic [DIM_W:0]        trial;
   logic [ROW_W+DIVIDEND_W:0] new_row;
   logic                  at_end;

   // Colour mix.
   logic [7:0]  alpha, ialpha;
   logic [12:0] rsum_ff, bsum_ff;
   logic [13:0] gsum_ff;
   logic [5:0]  rmix, gmix, bmix;
   logic [COLOR_W-1:0] mixed, color_sel;

   // Result registers.
   logic [COLOR_W-1:0] color_ff;
   logic [LEN_W-1:0]   rlen_ff;
   logic [POS_W-1:0]   scol_ff, srow_ff;
   logic               end_ff;

   function automatic logic [5:0] div255(input logic [13:0] s);
      logic [14:0] x;
      logic [14:0] y;
      x = 15'(s) + 15'd127;
      y = 15'(x + (x >> 8) + 15'd1);
      return 6'(y >> 8);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         obj_ff    <= OBJ_COLOR_RESET;
         bck_ff    <= BCK_COLOR_RESET;
         lwidth_ff <= WIDTH_RESET;
         lcount_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:       mode_ff   <= csr_write_data[0];
            CSR_OBJ_COLOR:  obj_ff    <= csr_write_data;
            CSR_BCK_COLOR:  bck_ff    <= csr_write_data;
            CSR_LINE_WIDTH: lwidth_ff <= csr_write_data[DIM_W-1:0];
            CSR_LINE_COUNT: lcount_ff <= csr_write_data[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (lwidth_ff == '0) begin
         wdim = DIM_W'(1);
      end else if (lwidth_ff > DIM_W'(MAX_COLUMNS)) begin
         wdim = DIM_W'(MAX_COLUMNS);
      end else begin
         wdim = lwidth_ff;
      end
      if (lcount_ff == '0) begin
         hdim = DIM_W'(1);
      end else if (lcount_ff > DIM_W'(MAX_ROWS)) begin
         hdim = DIM_W'(MAX_ROWS);
      end else begin
         hdim = lcount_ff;
      end
   end

   // Start of image clears phase, count and position ahead of the word.
   always_comb begin
      eff_phase = req_start_of_image ? PH_HEADER : phase_ff;
      eff_count = req_start_of_image ? '0 : count_ff;
      eff_col   = req_start_of_image ? '0 : col_ff;
      eff_row   = req_start_of_image ? '0 : row_ff;
      status.header_word = (eff_phase == PH_HEADER);

      hdr_sext    = mode_ff ? req_code_word : {{8{req_code_word[7]}}, req_code_word[7:0]};
      hdr_neg     = CODE_W'(CODE_W'(0) - hdr_sext);
      hdr_neg_sat = hdr_neg[CODE_W-1] ? {LEN_W{1'b1}} : hdr_neg[LEN_W-1:0];

      if (eff_phase == PH_REPEAT) begin
         run_len = (eff_count == '0) ? LEN_W'(1) : eff_count;
      end else begin
         run_len = LEN_W'(1);
      end
      lit_left = (eff_count == '0) ? '0 : LEN_W'(eff_count - 1'b1);
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (cmd.accept) begin
         phase_in = eff_phase;
         count_in = eff_count;
         case (eff_phase)
            PH_HEADER: begin
               if (hdr_sext[CODE_W-1]) begin
                  phase_in = PH_LITERAL;
                  count_in = hdr_neg_sat;
               end else if (hdr_sext[LEN_W-1:0] != '0) begin
                  phase_in = PH_REPEAT;
                  count_in = hdr_sext[LEN_W-1:0];
               end
            end
            PH_REPEAT: begin
               phase_in = PH_HEADER;
               count_in = '0;
            end
            default: begin
               count_in = lit_left;
               if (lit_left == '0) begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   // Four restoring steps of (column + length) / width per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      trial   = '0;
      if (cmd.accept) begin
         quot_in = DIVIDEND_W'(eff_col) + DIVIDEND_W'(run_len);
         rem_in  = '0;
      end else if (cmd.div_step) begin
         for (int i = 0; i < DIV_BITS_STEP; i++) begin
            trial   = {rem_in, quot_in[DIVIDEND_W-1]};
            quot_in = {quot_in[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, wdim}) begin
               rem_in     = DIM_W'(trial - {1'b0, wdim});
               quot_in[0] = 1'b1;
            end else begin
               rem_in = trial[DIM_W-1:0];
            end
         end
      end
   end

   // The run reaches the image end exactly when row + quotient >= height.
   always_comb begin
      new_row = (ROW_W+DIVIDEND_W+1)'(row_ff) + (ROW_W+DIVIDEND_W+1)'(quot_ff);
      at_end  = (new_row >= (ROW_W+DIVIDEND_W+1)'(hdim));
      col_in  = col_ff;
      row_in  = row_ff;
      if (cmd.accept) begin
         col_in = eff_col;
         row_in = eff_row;
      end else if (cmd.emit) begin
         col_in = at_end ? '0 : rem_ff[COL_W-1:0];
         row_in = at_end ? '0 : new_row[ROW_W-1:0];
      end
   end

   always_comb begin
      alpha     = word_ff[7:0];
      ialpha    = ~alpha;
      rmix      = div255({1'b0, rsum_ff});
      gmix      = div255(gsum_ff);
      bmix      = div255({1'b0, bsum_ff});
      mixed     = {rmix[4:0], gmix, bmix[4:0]};
      color_sel = (mode_ff == MODE_ALPHA) ? mixed : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (cmd.accept) begin
         word_ff <= req_code_word;
         len_ff  <= run_len;
      end
      if (cmd.mix) begin
         rsum_ff <= 13'(13'(obj_ff[15:11]) * 13'(alpha) + 13'(bck_ff[15:11]) * 13'(ialpha));
         gsum_ff <= 14'(14'(obj_ff[10:5]) * 14'(alpha) + 14'(bck_ff[10:5]) * 14'(ialpha));
         bsum_ff <= 13'(13'(obj_ff[4:0]) * 13'(alpha) + 13'(bck_ff[4:0]) * 13'(ialpha));
      end
      if (cmd.emit) begin
         color_ff <= color_sel;
         rlen_ff  <= len_ff;
         scol_ff  <= POS_W'(col_ff);
         srow_ff  <= POS_W'(row_ff);
         end_ff   <= at_end;
      end
   end

   assign rsp_color        = color_ff;
   assign rsp_run_length   = rlen_ff;
   assign rsp_start_column = scol_ff;
   assign rsp_start_row    = srow_ff;
   assign rsp_image_end    = end_ff;

endmodule

>>> design/rle_image_run_decoder_unit.sv
// Top level of the run-length image decoder, a controller and a datapath.
// A header beat is taken without leaving the idle state, so the input stays ready.
// A value beat passes through acceptance, the divider steps for (column + length) / width
// at four quotient bits per cycle, then the output register load, held while a result is unread.
// Reset is synchronous and returns configuration and position to defaults; there is no clearing pass.
`include "rle_image_run_decoder_unit_defines.svh"
module rle_image_run_decoder_unit #(
   parameter int MAX_COLUMNS = rid_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = rid_pkg::DEF_MAX_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [rid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rid_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rid_pkg::CODE_W-1:0]     req_code_word,
   input  logic                           req_start_of_image,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rid_pkg::COLOR_W-1:0]    rsp_color,
   output logic [rid_pkg::LEN_W-1:0]      rsp_run_length,
   output logic [rid_pkg::POS_W-1:0]      rsp_start_column,
   output logic [rid_pkg::POS_W-1:0]      rsp_start_row,
   output logic                           rsp_image_end
);
   import rid_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller sequences each value beat through the shared divider and
   // owns the result handshake. The output register lets a new input beat be
   // taken while the previous result still waits for the consumer.
   rid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the decoder phase and the current
   // position. Rather than multiplying out the linear pixel index, it divides
   // column plus run length by the width: the quotient advances the row, the
   // remainder is the new column, and the image end is reached once the new
   // row is at or beyond the configured height.
   rid_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_code_word      (req_code_word),
      .req_start_of_image (req_start_of_image),
      .cmd                (cmd),
      .status             (status),
      .rsp_color          (rsp_color),
      .rsp_run_length     (rsp_run_length),
      .rsp_start_column   (rsp_start_column),
      .rsp_start_row      (rsp_start_row),
      .rsp_image_end      (rsp_image_end)
   );

   // A header beat never makes the block busy.
   `RID_ASSERT_NEXT(a_header_one_cycle, req_valid && req_ready && status.header_word, req_ready, "header beat stalled the input")
   // A value beat always occupies the divider for the following cycles.
   `RID_ASSERT_NEXT(a_value_busy, req_valid && req_ready && !status.header_word, !req_ready, "input ready during division")
   // Every run covers at least one pixel.
   `RID_ASSERT_NOW(a_len_nonzero, rsp_valid, rsp_run_length != '0, "zero length run")
   // The start column stays inside the largest supported line.
   `RID_ASSERT_NOW(a_col_bound, rsp_valid, rsp_start_column < MAX_COLUMNS, "column beyond line limit")

endmodule
